[design/wildcard_mask_matcher_macros.svh]
// Assertion macros shared by the wildcard mask matcher checker.
`ifndef WILDCARD_MASK_MATCHER_MACROS_SVH
`define WILDCARD_MASK_MATCHER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define WMM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define WMM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/wmm_pkg.sv]
// Types, codes and helper functions for the wildcard mask matcher.
package wmm_pkg;

  // Input command codes.
  localparam logic [1:0] CMD_MASK = 2'd0;
  localparam logic [1:0] CMD_NAME = 2'd1;
  localparam logic [1:0] CMD_END  = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MASK_OVF = 2'd1;
  localparam logic [1:0] ST_NAME_OVF = 2'd2;

  // Wildcard code units.
  localparam logic [15:0] UNIT_QUESTION = 16'h003F;
  localparam logic [15:0] UNIT_STAR     = 16'h002A;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] code_unit;
    logic        first;
  } in_t;

  typedef struct packed {
    logic       matched;
    logic [1:0] status;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH_RD,
    S_MATCH_CMP,
    S_TAIL_RD,
    S_TAIL_CMP,
    S_DONE
  } state_t;

  // Fold ASCII upper case letters to lower case; all other units pass.
  function automatic logic [15:0] fold_unit(input logic [15:0] u);
    if (u >= 16'h0041 && u <= 16'h005A) begin
      return u + 16'h0020;
    end
    return u;
  endfunction

endpackage

[design/wmm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module wmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/wildcard_mask_matcher.sv]
// Wildcard mask matcher: stores a mask and a name, then matches them with '?' and '*'.
// Mask and name units are taken one per cycle while the matcher is idle; an end-of-name
// transaction holds off input until its result has moved into the output register. With an
// overflow flag set the matcher goes straight to its done state; else each compare step reads
// the RAMs, then compares, and each trailing star is read and compared the same way, until a
// mismatch with no star or the end of the mask. Synchronous reset clears lengths and flags.
module wildcard_mask_matcher #(
  parameter int MAX_MASK = 64,
  parameter int MAX_NAME = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  wmm_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output wmm_pkg::out_t out_data
);

  localparam int MAW = (MAX_MASK > 1) ? $clog2(MAX_MASK) : 1;
  localparam int NAW = (MAX_NAME > 1) ? $clog2(MAX_NAME) : 1;
  localparam int MLW = $clog2(MAX_MASK + 1);
  localparam int NLW = $clog2(MAX_NAME + 1);
  localparam logic [MLW-1:0] MASK_FULL = MLW'(MAX_MASK);
  localparam logic [NLW-1:0] NAME_FULL = NLW'(MAX_NAME);

  wmm_pkg::state_t state_r, state_nxt;

  logic [MLW-1:0] mlen_r, mlen_nxt;
  logic           movf_r, movf_nxt;
  logic [NLW-1:0] nlen_r, nlen_nxt;
  logic           novf_r, novf_nxt;
  logic [MLW-1:0] mi_r, mi_nxt;
  logic [NLW-1:0] ni_r, ni_nxt;
  logic [MLW-1:0] star_r, star_nxt;
  logic [NLW-1:0] resume_r, resume_nxt;
  logic           have_star_r, have_star_nxt;
  wmm_pkg::out_t  res_r, res_nxt;
  logic           out_valid_r, out_valid_nxt;
  wmm_pkg::out_t  out_data_r, out_data_nxt;

  logic           accept;
  logic           mask_we, name_we;
  logic [MAW-1:0] mask_waddr;
  logic [15:0]    mask_q, name_q;

  // Shared compare unit signals.
  logic [15:0] c_fold, m_fold;
  logic        mi_lt, ni_lt, unit_hit, unit_star, tail_star, out_free;

  assign in_ready  = (state_r == wmm_pkg::S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  // Store writes for mask and name units.
  assign mask_we    = accept && (in_data.cmd == wmm_pkg::CMD_MASK) &&
                      (in_data.first || (mlen_r < MASK_FULL));
  assign mask_waddr = in_data.first ? '0 : mlen_r[MAW-1:0];
  assign name_we    = accept && (in_data.cmd == wmm_pkg::CMD_NAME) && (nlen_r < NAME_FULL);

  wmm_ram #(.WIDTH(16), .DEPTH(MAX_MASK), .AW(MAW)) u_mask_ram (
    .clk   (clk),
    .we    (mask_we),
    .waddr (mask_waddr),
    .wdata (in_data.code_unit),
    .raddr (mi_r[MAW-1:0]),
    .rdata (mask_q)
  );

  wmm_ram #(.WIDTH(16), .DEPTH(MAX_NAME), .AW(NAW)) u_name_ram (
    .clk   (clk),
    .we    (name_we),
    .waddr (nlen_r[NAW-1:0]),
    .wdata (in_data.code_unit),
    .raddr (ni_r[NAW-1:0]),
    .rdata (name_q)
  );

  // Folding and comparison of the current mask and name units.
  always_comb begin
    c_fold    = wmm_pkg::fold_unit(name_q);
    m_fold    = wmm_pkg::fold_unit(mask_q);
    mi_lt     = (mi_r < mlen_r);
    ni_lt     = (ni_r < nlen_r);
    unit_hit  = (m_fold == wmm_pkg::UNIT_QUESTION) || (m_fold == c_fold);
    unit_star = (m_fold == wmm_pkg::UNIT_STAR);
    tail_star = (mask_q == wmm_pkg::UNIT_STAR);
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wmm_pkg::S_IDLE: begin
        if (accept && (in_data.cmd == wmm_pkg::CMD_END)) begin
          if (movf_r || novf_r) begin
            state_nxt = wmm_pkg::S_DONE;
          end else begin
            state_nxt = wmm_pkg::S_MATCH_RD;
          end
        end
      end
      wmm_pkg::S_MATCH_RD: begin
        state_nxt = ni_lt ? wmm_pkg::S_MATCH_CMP : wmm_pkg::S_TAIL_RD;
      end
      wmm_pkg::S_MATCH_CMP: begin
        if ((mi_lt && (unit_hit || unit_star)) || have_star_r) begin
          state_nxt = wmm_pkg::S_MATCH_RD;
        end else begin
          state_nxt = wmm_pkg::S_DONE;
        end
      end
      wmm_pkg::S_TAIL_RD: begin
        state_nxt = mi_lt ? wmm_pkg::S_TAIL_CMP : wmm_pkg::S_DONE;
      end
      wmm_pkg::S_TAIL_CMP: begin
        state_nxt = tail_star ? wmm_pkg::S_TAIL_RD : wmm_pkg::S_DONE;
      end
      wmm_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = wmm_pkg::S_IDLE;
        end
      end
      default: state_nxt = wmm_pkg::S_IDLE;
    endcase
  end

  // Datapath and output logic of the sequencer.
  always_comb begin
    mlen_nxt      = mlen_r;
    movf_nxt      = movf_r;
    nlen_nxt      = nlen_r;
    novf_nxt      = novf_r;
    mi_nxt        = mi_r;
    ni_nxt        = ni_r;
    star_nxt      = star_r;
    resume_nxt    = resume_r;
    have_star_nxt = have_star_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      wmm_pkg::S_IDLE: begin
        if (accept) begin
          unique case (in_data.cmd)
            wmm_pkg::CMD_MASK: begin
              if (in_data.first) begin
                mlen_nxt = MLW'(1);
                movf_nxt = 1'b0;
              end else if (mlen_r < MASK_FULL) begin
                mlen_nxt = mlen_r + MLW'(1);
              end else begin
                movf_nxt = 1'b1;
              end
            end
            wmm_pkg::CMD_NAME: begin
              if (nlen_r < NAME_FULL) begin
                nlen_nxt = nlen_r + NLW'(1);
              end else begin
                novf_nxt = 1'b1;
              end
            end
            wmm_pkg::CMD_END: begin
              mi_nxt          = '0;
              ni_nxt          = '0;
              star_nxt        = '0;
              resume_nxt      = '0;
              have_star_nxt   = 1'b0;
              res_nxt.matched = 1'b0;
              if (movf_r) begin
                res_nxt.status = wmm_pkg::ST_MASK_OVF;
              end else if (novf_r) begin
                res_nxt.status = wmm_pkg::ST_NAME_OVF;
              end else begin
                res_nxt.status = wmm_pkg::ST_OK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      wmm_pkg::S_MATCH_RD: begin
      end
      wmm_pkg::S_MATCH_CMP: begin
        if (mi_lt && unit_hit) begin
          mi_nxt = mi_r + MLW'(1);
          ni_nxt = ni_r + NLW'(1);
        end else if (mi_lt && unit_star) begin
          have_star_nxt = 1'b1;
          star_nxt      = mi_r;
          resume_nxt    = ni_r;
          mi_nxt        = mi_r + MLW'(1);
        end else if (have_star_r) begin
          // Backtrack: the last star swallows one more name unit.
          mi_nxt     = star_r + MLW'(1);
          resume_nxt = resume_r + NLW'(1);
          ni_nxt     = resume_r + NLW'(1);
        end
      end
      wmm_pkg::S_TAIL_RD: begin
        if (!mi_lt) begin
          res_nxt.matched = (mi_r == mlen_r);
        end
      end
      wmm_pkg::S_TAIL_CMP: begin
        if (tail_star) begin
          mi_nxt = mi_r + MLW'(1);
        end
      end
      wmm_pkg::S_DONE: begin
        // Deliver the result and start a fresh name.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          nlen_nxt      = '0;
          novf_nxt      = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wmm_pkg::S_IDLE;
      mlen_r      <= '0;
      movf_r      <= 1'b0;
      nlen_r      <= '0;
      novf_r      <= 1'b0;
      have_star_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mlen_r      <= mlen_nxt;
      movf_r      <= movf_nxt;
      nlen_r      <= nlen_nxt;
      novf_r      <= novf_nxt;
      have_star_r <= have_star_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and index registers.
  always_ff @(posedge clk) begin
    mi_r       <= mi_nxt;
    ni_r       <= ni_nxt;
    star_r     <= star_nxt;
    resume_r   <= resume_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

[design/wmm_checker.sv]
// Port-level checker for the wildcard mask matcher, with its bind statement.
`include "wildcard_mask_matcher_macros.svh"

module wmm_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input wmm_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_ready,
  input wmm_pkg::out_t out_data
);

  // A stalled result keeps its value.
  `WMM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

  // An end-of-name transaction starts the matcher, which blocks further input.
  `WMM_ASSERT_NXT(a_end_busy, in_valid && in_ready && (in_data.cmd == wmm_pkg::CMD_END), !in_ready, "input taken while matching")

  // A match is only reported with a clean status.
  `WMM_ASSERT_IMP(a_match_ok, out_valid && out_data.matched, out_data.status == wmm_pkg::ST_OK, "match reported with overflow status")

  // The status is always one of the defined codes.
  `WMM_ASSERT_IMP(a_status_code, out_valid, (out_data.status == wmm_pkg::ST_OK) || (out_data.status == wmm_pkg::ST_MASK_OVF) || (out_data.status == wmm_pkg::ST_NAME_OVF), "undefined status code")

endmodule

bind wildcard_mask_matcher wmm_checker u_wmm_checker (.*);

[dv/tb_wildcard_mask_matcher.sv]
// Self-checking testbench for the wildcard mask matcher: directed and random traffic.
`timescale 1ns / 100ps

module tb_wildcard_mask_matcher;

  localparam int MASK_DEPTH = 64;
  localparam int NAME_DEPTH = 256;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 850;
  localparam int LONG_HOLD = 400;
  localparam int QUIET_LIMIT = 200000;

  typedef enum int {
    SINK_ALWAYS,
    SINK_COIN,
    SINK_MOSTLY,
    SINK_PERIODIC
  } sink_mode_t;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  wmm_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  wmm_pkg::out_t out_data;

  wildcard_mask_matcher #(
    .MAX_MASK(MASK_DEPTH),
    .MAX_NAME(NAME_DEPTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  // Mirror of the matcher state, updated on every accepted input transaction.
  logic [15:0] mask_mem [MASK_DEPTH];
  logic [15:0] name_mem [NAME_DEPTH];
  int mask_len = 0;
  int name_len = 0;
  bit mask_ovf = 1'b0;
  bit name_ovf = 1'b0;

  // Verdicts still owed by the block, oldest first.
  wmm_pkg::out_t verdict_q[$];

  logic [15:0] mask_buf[$];
  logic [15:0] name_buf[$];
  int mismatches = 0;
  int sent_items = 0;
  int burst_left = 0;
  bit hold_request = 1'b0;

  // 125 MHz clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Only ASCII capitals are folded; everything else compares as it stands.
  function automatic logic [15:0] lower_ascii(input logic [15:0] u);
    if (u >= 16'h0041 && u <= 16'h005A) begin
      return u + 16'h0020;
    end
    return u;
  endfunction

  // Greedy glob match with a single backtrack point at the most recent star.
  function automatic bit glob_match();
    int mi;
    int ni;
    int star_at;
    int resume;
    bit have_star;
    bit stepped;
    logic [15:0] c;
    logic [15:0] m;
    mi = 0;
    ni = 0;
    star_at = 0;
    resume = 0;
    have_star = 1'b0;
    while (ni < name_len) begin
      c = lower_ascii(name_mem[ni]);
      stepped = 1'b0;
      if (mi < mask_len) begin
        m = lower_ascii(mask_mem[mi]);
        // A literal or a question mark is tried before a star is taken.
        if (m == wmm_pkg::UNIT_QUESTION || m == c) begin
          mi++;
          ni++;
          stepped = 1'b1;
        end else if (m == wmm_pkg::UNIT_STAR) begin
          have_star = 1'b1;
          star_at = mi;
          resume = ni;
          mi++;
          stepped = 1'b1;
        end
      end
      if (!stepped) begin
        if (!have_star) begin
          return 1'b0;
        end
        mi = star_at + 1;
        resume++;
        ni = resume;
      end
    end
    // Trailing stars match the empty remainder.
    while (mi < mask_len && mask_mem[mi] == wmm_pkg::UNIT_STAR) begin
      mi++;
    end
    return mi == mask_len;
  endfunction

  // Apply one accepted transaction to the mirrored state.
  function automatic void absorb_item(input wmm_pkg::in_t it);
    wmm_pkg::out_t v;
    case (it.cmd)
      wmm_pkg::CMD_MASK: begin
        if (it.first) begin
          mask_len = 0;
          mask_ovf = 1'b0;
        end
        if (mask_len < MASK_DEPTH) begin
          mask_mem[mask_len] = it.code_unit;
          mask_len++;
        end else begin
          mask_ovf = 1'b1;
        end
      end
      wmm_pkg::CMD_NAME: begin
        if (name_len < NAME_DEPTH) begin
          name_mem[name_len] = it.code_unit;
          name_len++;
        end else begin
          name_ovf = 1'b1;
        end
      end
      wmm_pkg::CMD_END: begin
        v.matched = 1'b0;
        v.status = wmm_pkg::ST_OK;
        if (mask_ovf) begin
          v.status = wmm_pkg::ST_MASK_OVF;
        end else if (name_ovf) begin
          v.status = wmm_pkg::ST_NAME_OVF;
        end else begin
          v.matched = glob_match();
        end
        verdict_q.push_back(v);
        name_len = 0;
        name_ovf = 1'b0;
      end
      default: begin
      end
    endcase
  endfunction

  // Offer one transaction, with bursts and random gaps, and wait for acceptance.
  task automatic send_item(input logic [1:0] cmd, input logic [15:0] cu, input logic first);
    int gap;
    wmm_pkg::in_t it;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 24);
    end
    burst_left--;
    it.cmd = cmd;
    it.code_unit = cu;
    it.first = first;
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    absorb_item(it);
    if (cmd != CMD_UNUSED) begin
      sent_items++;
    end
  endtask

  // Stop offering and wait until every owed verdict has been delivered.
  task automatic await_verdicts();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic load_mask_buf();
    foreach (mask_buf[i]) begin
      send_item(wmm_pkg::CMD_MASK, mask_buf[i], i == 0);
    end
  endtask

  // The first flag on name units and on the end transaction is random, as it is ignored.
  task automatic run_name_buf();
    foreach (name_buf[i]) begin
      send_item(wmm_pkg::CMD_NAME, name_buf[i], 1'($urandom_range(0, 1)));
    end
    send_item(wmm_pkg::CMD_END, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
  endtask

  task automatic load_mask_text(input string s);
    mask_buf.delete();
    for (int i = 0; i < s.len(); i++) begin
      mask_buf.push_back({8'h00, s[i]});
    end
    load_mask_buf();
  endtask

  task automatic run_name_text(input string s);
    name_buf.delete();
    for (int i = 0; i < s.len(); i++) begin
      name_buf.push_back({8'h00, s[i]});
    end
    run_name_buf();
  endtask

  // Letters from a tiny alphabet in both cases make backtracking likely.
  function automatic logic [15:0] random_unit(input bit for_mask);
    int r;
    r = $urandom_range(0, 99);
    if (for_mask && r < 15) begin
      return wmm_pkg::UNIT_STAR;
    end
    if (for_mask && r < 25) begin
      return wmm_pkg::UNIT_QUESTION;
    end
    if (r < 70) begin
      return ($urandom_range(0, 1) ? 16'h0041 : 16'h0061) + 16'($urandom_range(0, 2));
    end
    if (r < 82) begin
      return 16'($urandom_range(16'h0020, 16'h007F));
    end
    if (r < 88) begin
      return $urandom_range(0, 1) ? wmm_pkg::UNIT_STAR : wmm_pkg::UNIT_QUESTION;
    end
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [15:0] flip_case(input logic [15:0] u);
    if ($urandom_range(0, 1) == 0) begin
      return u;
    end
    if (u >= 16'h0041 && u <= 16'h005A) begin
      return u + 16'h0020;
    end
    if (u >= 16'h0061 && u <= 16'h007A) begin
      return u - 16'h0020;
    end
    return u;
  endfunction

  // An empty mask can only be seen straight after reset, before any mask is loaded.
  task automatic test_empty_operands();
    run_name_text("");
    run_name_text("a");
    load_mask_text("*");
    run_name_text("");
    load_mask_text("**");
    run_name_text("");
    load_mask_text("?");
    run_name_text("");
    await_verdicts();
  endtask

  task automatic test_case_folding();
    load_mask_text("AbZ@[");
    run_name_text("aBz@[");
    run_name_text("abz`{");
    // Units outside ASCII are compared without folding.
    mask_buf.delete();
    mask_buf.push_back(16'h00C4);
    mask_buf.push_back(16'hFFFF);
    mask_buf.push_back(16'h0000);
    load_mask_buf();
    name_buf.delete();
    name_buf.push_back(16'h00E4);
    name_buf.push_back(16'hFFFF);
    name_buf.push_back(16'h0000);
    run_name_buf();
    name_buf[0] = 16'h00C4;
    run_name_buf();
    name_buf[2] = 16'h8000;
    run_name_buf();
    await_verdicts();
  endtask

  task automatic test_question_mark();
    load_mask_text("a?c");
    run_name_text("abc");
    run_name_text("ac");
    run_name_text("a?c");
    run_name_text("abcd");
    load_mask_text("??");
    run_name_text("x");
    await_verdicts();
  endtask

  task automatic test_star_backtracking();
    load_mask_text("*ab*c");
    run_name_text("xaabyc");
    run_name_text("abc");
    run_name_text("ab");
    load_mask_text("a*b*c");
    run_name_text("abbbc");
    run_name_text("acb");
    // A star in the name is first taken as a literal against a star in the mask.
    load_mask_text("*?");
    run_name_text("*");
    run_name_text("");
    load_mask_text("*ab");
    run_name_text("aaaaaaaaaaaaaaaaaaaab");
    await_verdicts();
  endtask

  // First flag: appending without it, and ignored items in between.
  task automatic test_first_flag_and_unused();
    load_mask_text("ab");
    send_item(CMD_UNUSED, 16'($urandom_range(0, 65535)), 1'b1);
    send_item(wmm_pkg::CMD_MASK, 16'h0063, 1'b0);
    send_item(CMD_UNUSED, 16'hFFFF, 1'b0);
    run_name_text("abc");
    send_item(wmm_pkg::CMD_MASK, 16'h0078, 1'b1);
    run_name_text("abc");
    run_name_text("X");
    await_verdicts();
  endtask

  task automatic test_mask_overflow();
    // A mask that exactly fills the store is still matched.
    for (int i = 0; i < MASK_DEPTH; i++) begin
      send_item(wmm_pkg::CMD_MASK, (i == MASK_DEPTH - 1) ? 16'h007A : wmm_pkg::UNIT_STAR,
                i == 0);
    end
    run_name_text("az");
    send_item(wmm_pkg::CMD_MASK, 16'h0061, 1'b0);
    run_name_text("az");
    // With both stores overflowed the mask status wins.
    for (int i = 0; i <= NAME_DEPTH; i++) begin
      send_item(wmm_pkg::CMD_NAME, 16'h0061, 1'b0);
    end
    send_item(wmm_pkg::CMD_END, 16'h0000, 1'b0);
    run_name_text("");
    load_mask_text("*");
    run_name_text("q");
    await_verdicts();
  endtask

  task automatic test_name_overflow();
    load_mask_text("*");
    for (int i = 0; i < NAME_DEPTH; i++) begin
      send_item(wmm_pkg::CMD_NAME, 16'($urandom_range(0, 65535)), 1'b0);
    end
    send_item(wmm_pkg::CMD_END, 16'hFFFF, 1'b1);
    for (int i = 0; i <= NAME_DEPTH; i++) begin
      send_item(wmm_pkg::CMD_NAME, 16'($urandom_range(0, 65535)), 1'b1);
    end
    send_item(wmm_pkg::CMD_END, 16'h0000, 1'b0);
    // The name overflow clears once its result has been given.
    run_name_text("q");
    await_verdicts();
  endtask

  // Long receiver hold-off while the sender keeps offering transactions.
  task automatic test_result_backpressure();
    hold_request = 1'b1;
    repeat (8) begin
      load_mask_text("a*b?");
      run_name_text("aXXbc");
      run_name_text("ab");
    end
    await_verdicts();
  endtask

  task automatic test_random_traffic();
    int start;
    int len;
    int r;
    logic [15:0] u;
    start = sent_items;
    mask_buf.delete();
    while (sent_items - start < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        // Noise: loose transactions of any kind, including the unused code.
        repeat ($urandom_range(1, 4)) begin
          send_item(2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                    1'($urandom_range(0, 1)));
        end
        mask_buf.delete();
      end else begin
        if (r < 50 || mask_buf.size() == 0) begin
          r = $urandom_range(0, 99);
          if (r < 3) begin
            len = $urandom_range(MASK_DEPTH + 1, MASK_DEPTH + 4);
          end else if (r < 8) begin
            len = $urandom_range(20, MASK_DEPTH);
          end else begin
            len = $urandom_range(1, 8);
          end
          mask_buf.delete();
          repeat (len) mask_buf.push_back(random_unit(1'b1));
          load_mask_buf();
        end
        repeat ($urandom_range(1, 3)) begin
          name_buf.delete();
          r = $urandom_range(0, 99);
          if (r < 60) begin
            // Expand the mask into a name that should mostly match.
            foreach (mask_buf[i]) begin
              u = mask_buf[i];
              if (u == wmm_pkg::UNIT_STAR) begin
                repeat ($urandom_range(0, 3)) name_buf.push_back(random_unit(1'b0));
              end else if (u == wmm_pkg::UNIT_QUESTION) begin
                name_buf.push_back(random_unit(1'b0));
              end else begin
                name_buf.push_back(flip_case(u));
              end
            end
            if ($urandom_range(0, 9) < 3 && name_buf.size() != 0) begin
              if ($urandom_range(0, 1) == 1) begin
                name_buf[$urandom_range(0, name_buf.size() - 1)] = random_unit(1'b0);
              end else begin
                void'(name_buf.pop_back());
              end
            end
          end else begin
            if (r < 62) begin
              len = $urandom_range(NAME_DEPTH + 1, NAME_DEPTH + 6);
            end else if (r < 65) begin
              len = $urandom_range(100, NAME_DEPTH);
            end else begin
              len = $urandom_range(0, 10);
            end
            repeat (len) name_buf.push_back(random_unit(1'b0));
          end
          run_name_buf();
        end
      end
    end
    await_verdicts();
  endtask

  // Receiver: the ready pattern switches between random modes, plus one long hold-off.
  initial begin : result_sink
    int hold_left;
    int mode_left;
    int phase;
    sink_mode_t mode;
    hold_left = 0;
    mode_left = 0;
    phase = 0;
    mode = SINK_ALWAYS;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LONG_HOLD;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = sink_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(50, 400);
        end
        mode_left--;
        case (mode)
          SINK_ALWAYS:   out_ready <= 1'b1;
          SINK_COIN:     out_ready <= ($urandom_range(0, 1) == 1);
          SINK_MOSTLY:   out_ready <= ($urandom_range(0, 9) != 0);
          SINK_PERIODIC: out_ready <= ((phase % 7) > 2);
          default:       out_ready <= 1'b1;
        endcase
      end
    end
  end

  task automatic report_field(input string field, input logic [1:0] want_v,
                              input logic [1:0] got_v);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
    end
  endtask

  // Compare each delivered result transaction with the oldest owed verdict.
  always @(posedge clk) begin : verdict_check
    wmm_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: unexpected result, matched %0b status %0d", $time,
                   out_data.matched, out_data.status);
        end
      end else begin
        want = verdict_q.pop_front();
        if (out_data.matched !== want.matched) begin
          report_field("matched", {1'b0, want.matched}, {1'b0, out_data.matched});
        end
        if (out_data.status !== want.status) begin
          report_field("status", want.status, out_data.status);
        end
      end
    end
  end

  // Ends the run if neither channel completes a transaction for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Test sequence.
  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_operands();
    test_case_folding();
    test_question_mark();
    test_star_backtracking();
    test_first_flag_and_unused();
    test_mask_overflow();
    test_name_overflow();
    test_result_backpressure();
    test_random_traffic();
    await_verdicts();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/wmm_pkg.sv
design/wmm_ram.sv
design/wildcard_mask_matcher.sv
design/wmm_checker.sv
dv/tb_wildcard_mask_matcher.sv
